// File: design/scancode_set1_to_ascii_decoder_assert.svh
// Assertion macros used by the decoder's top-level file.
`ifndef SCANCODE_SET1_TO_ASCII_DECODER_ASSERT_SVH
`define SCANCODE_SET1_TO_ASCII_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is asserted.
`define SC2A_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
		else $error(msg);

// Checked property that also holds during reset.
`define SC2A_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`else

`define SC2A_ASSERT(lbl, clk_sig, rstn_sig, prop, msg)
`define SC2A_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)

`endif

`endif

// File: design/sc2a_pkg.sv
package sc2a_pkg;

	localparam logic       OP_SCAN       = 1'b0;
	localparam logic       OP_READ       = 1'b1;

	localparam logic [7:0] PREFIX_BYTE   = 8'hE0;
	localparam logic [6:0] LSHIFT_MAKE   = 7'h2A;
	localparam logic [6:0] RSHIFT_MAKE   = 7'h36;
	localparam logic [6:0] CAPSLOCK_MAKE = 7'h3A;

	localparam logic [6:0] CHR_LOW_A     = 7'h61;
	localparam logic [6:0] CHR_LOW_Z     = 7'h7A;
	localparam logic [6:0] CHR_UP_A      = 7'h41;
	localparam logic [6:0] CHR_UP_Z      = 7'h5A;
	localparam logic [6:0] CASE_BIT      = 7'h20;

	// Keyboard state carried from one transaction to the next.
	typedef struct packed {
		logic       prefix;
		logic       shift;
		logic       caps;
		logic [6:0] held;
	} kbd_state_t;

	// One result transaction.
	typedef struct packed {
		logic       pending;
		logic       caps;
		logic       shift;
		logic [6:0] read_char;
	} result_t;

	function automatic logic [6:0] plain_char(input logic [6:0] code);
		logic [6:0] c;
		unique case (code)
			7'h01: c = 7'h1B;
			7'h02: c = 7'h31;
			7'h03: c = 7'h32;
			7'h04: c = 7'h33;
			7'h05: c = 7'h34;
			7'h06: c = 7'h35;
			7'h07: c = 7'h36;
			7'h08: c = 7'h37;
			7'h09: c = 7'h38;
			7'h0A: c = 7'h39;
			7'h0B: c = 7'h30;
			7'h0C: c = 7'h2D;
			7'h0D: c = 7'h3D;
			7'h0E: c = 7'h08;
			7'h0F: c = 7'h09;
			7'h10: c = 7'h71;
			7'h11: c = 7'h77;
			7'h12: c = 7'h65;
			7'h13: c = 7'h72;
			7'h14: c = 7'h74;
			7'h15: c = 7'h79;
			7'h16: c = 7'h75;
			7'h17: c = 7'h69;
			7'h18: c = 7'h6F;
			7'h19: c = 7'h70;
			7'h1A: c = 7'h5B;
			7'h1B: c = 7'h5D;
			7'h1C: c = 7'h0A;
			7'h1E: c = 7'h61;
			7'h1F: c = 7'h73;
			7'h20: c = 7'h64;
			7'h21: c = 7'h66;
			7'h22: c = 7'h67;
			7'h23: c = 7'h68;
			7'h24: c = 7'h6A;
			7'h25: c = 7'h6B;
			7'h26: c = 7'h6C;
			7'h27: c = 7'h3B;
			7'h28: c = 7'h27;
			7'h29: c = 7'h60;
			7'h2B: c = 7'h5C;
			7'h2C: c = 7'h7A;
			7'h2D: c = 7'h78;
			7'h2E: c = 7'h63;
			7'h2F: c = 7'h76;
			7'h30: c = 7'h62;
			7'h31: c = 7'h6E;
			7'h32: c = 7'h6D;
			7'h33: c = 7'h2C;
			7'h34: c = 7'h2E;
			7'h35: c = 7'h2F;
			7'h37: c = 7'h2A;
			7'h39: c = 7'h20;
			7'h4A: c = 7'h2D;
			7'h4E: c = 7'h2B;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] shifted_char(input logic [6:0] code);
		logic [6:0] c;
		unique case (code)
			7'h01: c = 7'h1B;
			7'h02: c = 7'h21;
			7'h03: c = 7'h40;
			7'h04: c = 7'h23;
			7'h05: c = 7'h24;
			7'h06: c = 7'h25;
			7'h07: c = 7'h5E;
			7'h08: c = 7'h26;
			7'h09: c = 7'h2A;
			7'h0A: c = 7'h28;
			7'h0B: c = 7'h29;
			7'h0C: c = 7'h5F;
			7'h0D: c = 7'h2B;
			7'h0E: c = 7'h08;
			7'h0F: c = 7'h09;
			7'h10: c = 7'h51;
			7'h11: c = 7'h57;
			7'h12: c = 7'h45;
			7'h13: c = 7'h52;
			7'h14: c = 7'h54;
			7'h15: c = 7'h59;
			7'h16: c = 7'h55;
			7'h17: c = 7'h49;
			7'h18: c = 7'h4F;
			7'h19: c = 7'h50;
			7'h1A: c = 7'h7B;
			7'h1B: c = 7'h7D;
			7'h1C: c = 7'h0A;
			7'h1E: c = 7'h41;
			7'h1F: c = 7'h53;
			7'h20: c = 7'h44;
			7'h21: c = 7'h46;
			7'h22: c = 7'h47;
			7'h23: c = 7'h48;
			7'h24: c = 7'h4A;
			7'h25: c = 7'h4B;
			7'h26: c = 7'h4C;
			7'h27: c = 7'h3A;
			7'h28: c = 7'h22;
			7'h29: c = 7'h7E;
			7'h2B: c = 7'h7C;
			7'h2C: c = 7'h5A;
			7'h2D: c = 7'h58;
			7'h2E: c = 7'h43;
			7'h2F: c = 7'h56;
			7'h30: c = 7'h42;
			7'h31: c = 7'h4E;
			7'h32: c = 7'h4D;
			7'h33: c = 7'h3C;
			7'h34: c = 7'h3E;
			7'h35: c = 7'h3F;
			7'h37: c = 7'h2A;
			7'h39: c = 7'h20;
			7'h4A: c = 7'h2D;
			7'h4E: c = 7'h2B;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

// File: design/sc2a_decode.sv
// Next-state and result logic for one transaction.
module sc2a_decode (
	input  logic                opcode,
	input  logic [7:0]          scan_byte,
	input  logic                input_enable,
	input  sc2a_pkg::kbd_state_t cur,
	output sc2a_pkg::kbd_state_t nxt,
	output sc2a_pkg::result_t   res
);

	logic       rel;
	logic [6:0] code;
	logic [6:0] looked_up;
	logic [6:0] ch;

	assign rel  = scan_byte[7];
	assign code = scan_byte[6:0];

	always_comb begin
		looked_up = cur.shift ? sc2a_pkg::shifted_char(code) : sc2a_pkg::plain_char(code);
		ch = looked_up;
		// Caps lock swaps the case of letters only.
		if (cur.caps && (((looked_up >= sc2a_pkg::CHR_LOW_A) && (looked_up <= sc2a_pkg::CHR_LOW_Z))
				|| ((looked_up >= sc2a_pkg::CHR_UP_A) && (looked_up <= sc2a_pkg::CHR_UP_Z)))) begin
			ch = looked_up ^ sc2a_pkg::CASE_BIT;
		end
	end

	always_comb begin
		nxt           = cur;
		res.read_char = 7'd0;
		if (opcode == sc2a_pkg::OP_READ) begin
			res.read_char = cur.held;
			nxt.held      = 7'd0;
		end else if (scan_byte == sc2a_pkg::PREFIX_BYTE) begin
			nxt.prefix = 1'b1;
		end else if (cur.prefix) begin
			nxt.prefix = 1'b0;
		end else if ((code == sc2a_pkg::LSHIFT_MAKE) || (code == sc2a_pkg::RSHIFT_MAKE)) begin
			nxt.shift = !rel;
		end else if (!rel && (code == sc2a_pkg::CAPSLOCK_MAKE)) begin
			nxt.caps = !cur.caps;
		end else if (!rel && input_enable && (ch != 7'd0)) begin
			nxt.held = ch;
		end
		res.shift   = nxt.shift;
		res.caps    = nxt.caps;
		res.pending = (nxt.held != 7'd0);
	end

endmodule

// File: design/scancode_set1_to_ascii_decoder.sv
// An input transaction is registered in the input stage, then moves into the result register on the master side.
// Throughput: one transaction per cycle while a waiting result is not stalled by m_tready low.
// The input register refills while a finished result waits for the consumer.
// Reset (arst_n low, asynchronous): all keyboard state, the held character,
// input_enable and both valid flags clear to zero.
`include "scancode_set1_to_ascii_decoder_assert.svh"

module scancode_set1_to_ascii_decoder (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration: input_enable register.
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,

	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] scan_byte
	input  logic        s_tuser,   // [0] opcode (0 = scan byte, 1 = read and clear)

	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [6:0] read_char, [7] shift_held, [8] caps_active,
	                               // [9] char_pending, [15:10] zero
);

	// Input register stage.
	logic                 valid_s1;
	logic                 opcode_s1;
	logic [7:0]           byte_s1;

	// Architectural state.
	logic                 enable_q;
	sc2a_pkg::kbd_state_t kbd_q;
	sc2a_pkg::kbd_state_t kbd_nxt;

	// Result register.
	logic                 out_valid_q;
	sc2a_pkg::result_t    res_q;
	sc2a_pkg::result_t    res_nxt;

	logic                 advance;

	// The stage-1 item moves into the result register whenever that register is
	// empty or its content is being taken in this cycle. Keyboard state updates
	// on the same edge, so the next item always sees the state this one leaves.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	sc2a_decode u_decode (
		.opcode       (opcode_s1),
		.scan_byte    (byte_s1),
		.input_enable (enable_q),
		.cur          (kbd_q),
		.nxt          (kbd_nxt),
		.res          (res_nxt)
	);

	// A configuration write of 1 also clears the held character. The user must write only while the block
	// is idle, so writes never meet an advancing item; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			kbd_q    <= '0;
		end else begin
			if (advance) begin
				kbd_q <= kbd_nxt;
			end
			if (cfg_wr_en) begin
				enable_q <= cfg_wr_data;
				if (cfg_wr_data) begin
					kbd_q.held <= 7'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q};

	// A read leaves nothing held behind it.
	`SC2A_ASSERT(a_read_clears, clk, arst_n, (advance && (opcode_s1 == sc2a_pkg::OP_READ)) |=> (kbd_q.held == 7'd0), "read did not clear held character")
	// A returned character means the hold register was just emptied.
	`SC2A_ASSERT(a_read_not_pending, clk, arst_n, (m_tvalid && (m_tdata[6:0] != 7'd0)) |-> !m_tdata[9], "read result still reports a pending character")
	// Input back-pressure only when both stages are occupied.
	`SC2A_ASSERT_ALWAYS(a_stall_full, clk, !s_tready |-> (valid_s1 && out_valid_q), "input stalled with a free stage")
	// Enabling input clears the held character.
	`SC2A_ASSERT(a_enable_clears, clk, arst_n, (cfg_wr_en && cfg_wr_data) |=> (kbd_q.held == 7'd0), "enable write did not clear held character")

endmodule
